// ===== hdl/gh_pkg.sv =====
// shared types, codes and helpers of the ghash accumulator
package gh_pkg;

	localparam int BLOCK_W = 128;
	localparam int HALF_W  = 64;
	localparam int NB_W    = 5;
	localparam int BYTES   = 16;

	typedef enum logic [1:0] {
		FUNC_AAD    = 2'd0,
		FUNC_TEXT   = 2'd1,
		FUNC_FINISH = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic {
		REG_KEY_HI = 1'b0,
		REG_KEY_LO = 1'b1
	} reg_idx_t;

	// one item as handed to the accumulator stage
	typedef struct packed {
		logic                vld;
		func_t               func;
		logic [BLOCK_W-1:0]  block;
		logic [NB_W-1:0]     nbytes;
	} item_t;

	// status back from the accumulator stage
	typedef struct packed {
		logic hold;
		logic finish;
	} stat_t;

	function automatic logic [NB_W-1:0] sat_bytes(input logic [NB_W-1:0] n);
		logic [NB_W-1:0] r;
		r = (n > NB_W'(BYTES)) ? NB_W'(BYTES) : n;
		return r;
	endfunction

	// byte 0 sits in the top eight bits
	function automatic logic [BLOCK_W-1:0] byte_mask(input logic [NB_W-1:0] n);
		logic [BLOCK_W-1:0] m;
		m = '0;
		for (int b = 0; b < BYTES; b++) begin
			if (NB_W'(b) < n) begin
				m[BLOCK_W-1-8*b -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

// ===== hdl/ghash_accumulator.sv =====
// ghash accumulator top level: input stage, key registers, output stream
//
//  channel  | dir | handshake             | payload
//  s_axis   | in  | s_axis_tvalid/tready  | tuser: func; tdata: data_hi, data_lo, valid_bytes
//  m_axis   | out | m_axis_tvalid/tready  | tdata: tag_hi, tag_lo
//  cfg      | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data (key halves)
//
// one block per cycle: input register, then one combinational gf(2^128) multiply
// into the accumulator; a finish item passes the input register, then the tag register
// arst_n clears accumulator, counters, key and all valid flags
// only a finish item is held on a stalled tag; data blocks in the input stage keep flowing
// cfg_ready is always high
module ghash_accumulator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,   // data_hi, data_lo, valid_bytes, zero pad
	input  logic [1:0]   s_axis_tuser,   // func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // tag_hi, tag_lo
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam int W = gh_pkg::BLOCK_W;
	localparam int H = gh_pkg::HALF_W;

	logic                    s1_vld;
	gh_pkg::func_t           func_s1;
	logic [W-1:0]            data_s1;
	logic [gh_pkg::NB_W-1:0] nb_s1;
	logic [H-1:0]            key_hi_q;
	logic [H-1:0]            key_lo_q;
	logic [gh_pkg::NB_W-1:0] nb_sat;
	gh_pkg::item_t           item;
	gh_pkg::stat_t           stat;
	logic [W-1:0]            tag;
	logic                    s_xfer;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !s1_vld || !stat.hold;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (gh_pkg::reg_idx_t'(cfg_index))
				gh_pkg::REG_KEY_HI: key_hi_q <= cfg_data;
				gh_pkg::REG_KEY_LO: key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else if (s_axis_tready) begin
			s1_vld <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			func_s1 <= gh_pkg::func_t'(s_axis_tuser);
			data_s1 <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
			nb_s1   <= s_axis_tdata[132:128];
		end
	end

	assign nb_sat = gh_pkg::sat_bytes(nb_s1);

	always_comb begin
		item.vld    = s1_vld;
		item.func   = func_s1;
		item.block  = data_s1 & gh_pkg::byte_mask(nb_sat);
		item.nbytes = nb_sat;
	end

	gh_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.key       ({key_hi_q, key_lo_q}),
		.tag_ready (m_axis_tready),
		.tag_q     (tag),
		.tag_vld_q (m_axis_tvalid),
		.stat      (stat)
	);

	assign m_axis_tdata = {tag[H-1:0], tag[W-1:H]};

	// a finish that leaves the input stage always shows up as a tag
	a_finish_tag: assert property (@(posedge clk) disable iff (!arst_n)
		stat.finish |=> m_axis_tvalid)
		else $error("finish did not produce a tag");

	// a held item stays in the input stage unchanged
	a_hold_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld && stat.hold) |=> (s1_vld && $stable(func_s1) && $stable(data_s1)))
		else $error("held item lost");

	// a new tag only ever comes from a finish item
	a_tag_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(stat.finish))
		else $error("tag without finish");

endmodule

// ===== hdl/gh_gfmul.sv =====
// gf(2^128) multiplier in gcm bit order, fully combinational
module gh_gfmul (
	input  logic [gh_pkg::BLOCK_W-1:0] x,
	input  logic [gh_pkg::BLOCK_W-1:0] h,
	output logic [gh_pkg::BLOCK_W-1:0] z
);

	localparam int W = gh_pkg::BLOCK_W;

	logic [2*W-2:0] c;
	logic [W+5:0]   d;
	logic [W-1:0]   e;

	// coefficient i of a value is its bit W-1-i
	always_comb begin
		c = '0;
		for (int i = 0; i < W; i++) begin
			for (int j = 0; j < W; j++) begin
				c[i+j] = c[i+j] ^ (x[W-1-i] & h[W-1-j]);
			end
		end
	end

	// reduce by x^128 + x^7 + x^2 + x + 1 in two passes
	always_comb begin
		d = {6'b000000, c[W-1:0]};
		for (int k = W; k < 2*W-1; k++) begin
			d[k-W]   = d[k-W]   ^ c[k];
			d[k-W+1] = d[k-W+1] ^ c[k];
			d[k-W+2] = d[k-W+2] ^ c[k];
			d[k-W+7] = d[k-W+7] ^ c[k];
		end
	end

	always_comb begin
		e = d[W-1:0];
		for (int k = W; k < W+6; k++) begin
			e[k-W]   = e[k-W]   ^ d[k];
			e[k-W+1] = e[k-W+1] ^ d[k];
			e[k-W+2] = e[k-W+2] ^ d[k];
			e[k-W+7] = e[k-W+7] ^ d[k];
		end
	end

	always_comb begin
		for (int i = 0; i < W; i++) begin
			z[W-1-i] = e[i];
		end
	end

endmodule

// ===== hdl/gh_state.sv =====
// accumulator, bit counters and tag output register
module gh_state (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gh_pkg::item_t               item,
	input  logic [gh_pkg::BLOCK_W-1:0]  key,
	input  logic                        tag_ready,
	output logic [gh_pkg::BLOCK_W-1:0]  tag_q,
	output logic                        tag_vld_q,
	output gh_pkg::stat_t               stat
);

	localparam int W = gh_pkg::BLOCK_W;
	localparam int H = gh_pkg::HALF_W;

	logic [W-1:0] acc_q;
	logic [H-1:0] aad_cnt_q;
	logic [H-1:0] text_cnt_q;
	logic [W-1:0] mul_in;
	logic [W-1:0] prod;
	logic [H-1:0] bits_add;
	logic         is_data;
	logic         is_fin;

	assign is_fin  = item.vld && (item.func == gh_pkg::FUNC_FINISH);
	assign is_data = item.vld && (item.nbytes != '0) &&
		((item.func == gh_pkg::FUNC_AAD) || (item.func == gh_pkg::FUNC_TEXT));

	assign stat.hold   = is_fin && tag_vld_q && !tag_ready;
	assign stat.finish = is_fin && !stat.hold;

	assign mul_in   = acc_q ^ (is_fin ? {aad_cnt_q, text_cnt_q} : item.block);
	assign bits_add = {{(H-gh_pkg::NB_W-3){1'b0}}, item.nbytes, 3'b000};

	gh_gfmul u_mul (
		.x (mul_in),
		.h (key),
		.z (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			aad_cnt_q  <= '0;
			text_cnt_q <= '0;
			tag_vld_q  <= 1'b0;
		end else begin
			tag_vld_q <= stat.finish || (tag_vld_q && !tag_ready);
			if (stat.finish) begin
				acc_q      <= '0;
				aad_cnt_q  <= '0;
				text_cnt_q <= '0;
			end else if (is_data) begin
				acc_q <= prod;
				if (item.func == gh_pkg::FUNC_AAD) begin
					aad_cnt_q <= aad_cnt_q + bits_add;
				end else begin
					text_cnt_q <= text_cnt_q + bits_add;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.finish) begin
			tag_q <= prod;
		end
	end

endmodule
